// ----- design/rtmp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtmp_pkg: shared types and constants for the roots-to-polynomial block
//
// Field widths of the request and result, the split used by the partial
// product multipliers, register indexes and the control bundle of a cell.
// ----------------------------------------------------------------------------
package rtmp_pkg;

  // Field widths.
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned COEF_W = 48;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned RC_W   = 4;

  // Operand split for the partial products: low half unsigned, high half
  // signed, both carried in PART_W bit signed operands.
  localparam int unsigned HALF_W = COEF_W / 2;
  localparam int unsigned PART_W = HALF_W + 1;

  // Defaults of the top level parameters.
  localparam int unsigned MAX_ROOTS_DEF = 8;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Configuration port.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_ROOT_COUNT = 1'b0;
  localparam logic REG_SIGN_SYM   = 1'b1;

  // One request: a complex root in Q16.16.
  typedef struct packed {
    logic signed [ROOT_W-1:0] root_re;
    logic signed [ROOT_W-1:0] root_im;
  } rtmp_req_t;

  // One result: a coefficient in Q32.16 with its flags.
  typedef struct packed {
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_re;
    logic signed [COEF_W-1:0] coef_im;
    logic                     saturated;
    logic                     last;
  } rtmp_res_t;

  // Control shared by all cells of the chain.
  typedef struct packed {
    logic       mac;
    logic       first;
    logic [1:0] phase;
    logic       commit;
    logic       shift;
    logic       clear;
  } rtmp_ctl_t;

endpackage

// ----- design/roots_to_monic_polynomial.sv -----
// ----------------------------------------------------------------------------
// roots_to_monic_polynomial: monic polynomial coefficients from complex roots
//
// Builds prod(z - r) over the roots of one element in a chain of cells and
// sends the non-leading coefficients after the last root.
// ----------------------------------------------------------------------------
// Usage. A request (one complex root, Q16.16) is taken on a clock edge with
// start high and busy low. The APB port sets root_count and sign_symmetry at
// byte addresses 0 and 4; write it only while busy is low.
// Timing. A root that is absorbed keeps busy high through the four
// partial-product phases of the 25 by 25 bit multipliers in every cell,
// then a commit step. With sign symmetry in force a squaring step comes
// first. A root beyond the used ones skips the multiply phases and commits
// nothing. After the n-th root the block sends n results, one per cycle,
// on result_o marked by result_valid_o; last marks the final one.
// The receiver cannot stall: each result is present for exactly one cycle.
// A new request is taken only when busy is low again, so the next root
// waits until the last one is through and, after the last root of an
// element, until its results are sent.
// Reset clears the coefficient store, the root count and the overflow flag
// at once; root_count resets to 1 and sign_symmetry to 0. After the last
// result the store is clear and busy is low in the next cycle.
// ----------------------------------------------------------------------------
module roots_to_monic_polynomial import rtmp_pkg::*; #(
  parameter int unsigned MAX_ROOTS = MAX_ROOTS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request channel.
  input  logic              start,
  output logic              busy,
  input  rtmp_req_t         req_i,
  // Result channel.
  output logic              result_valid_o,
  output rtmp_res_t         result_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CNT_W = $clog2(MAX_ROOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > RC_W) ? CNT_W : RC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [COEF_W-1:0] root_re_q, root_re_d, root_im_q, root_im_d;
  logic [1:0]        phase_q, phase_d;
  logic              absorb_q, absorb_d;
  logic [CNT_W-1:0]  seen_q, seen_d, seen_inc;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  emit_cnt_q, emit_cnt_d;
  logic [RC_W-1:0]   root_count_q;
  logic              sign_sym_q;

  logic [CMP_W-1:0]  rc_ext, n_cmp;
  logic [CNT_W-1:0]  n_roots, used;
  logic              sym, active, emit_last, any_sat;

  logic [COEF_W-1:0] sq_re, sq_im;
  logic              sq_sat;
  logic [PART_W-1:0] rpart_re, rpart_im;
  rtmp_ctl_t         ctl;

  logic [COEF_W-1:0]    cell_re [MAX_ROOTS];
  logic [COEF_W-1:0]    cell_im [MAX_ROOTS];
  logic [MAX_ROOTS-1:0] cell_sat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_count_q <= RC_W'(1);
      sign_sym_q   <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ROOT_COUNT: root_count_q <= pwdata[RC_W-1:0];
        REG_SIGN_SYM:   sign_sym_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROOT_COUNT: prdata = DATA_W'(root_count_q);
      REG_SIGN_SYM:   prdata = DATA_W'(sign_sym_q);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Effective root count, clamped to 1..MAX_ROOTS, and the used roots.
  assign rc_ext  = CMP_W'(root_count_q);
  assign n_cmp   = (rc_ext == '0) ? CMP_W'(1)
                 : (rc_ext > CMP_W'(MAX_ROOTS)) ? CMP_W'(MAX_ROOTS) : rc_ext;
  assign n_roots = CNT_W'(n_cmp);
  assign sym     = sign_sym_q & ~n_roots[0];
  assign used    = sym ? (n_roots >> 1) : n_roots;
  assign active  = seen_q < used;

  assign seen_inc  = (seen_q < CNT_W'(MAX_ROOTS)) ? seen_q + CNT_W'(1) : seen_q;
  assign emit_last = emit_cnt_q == n_roots - CNT_W'(1);

  // Squaring of the held root.
  rtmp_square #(
    .FRAC_BITS (FRAC_BITS)
  ) u_square (
    .re_i    (root_re_q[ROOT_W-1:0]),
    .im_i    (root_im_q[ROOT_W-1:0]),
    .sq_re_o (sq_re),
    .sq_im_o (sq_im),
    .sat_o   (sq_sat)
  );

  // Root half for the current phase, shared by all cells.
  assign rpart_re = phase_q[1] ? {root_re_q[COEF_W-1], root_re_q[COEF_W-1:HALF_W]}
                               : {1'b0, root_re_q[HALF_W-1:0]};
  assign rpart_im = phase_q[1] ? {root_im_q[COEF_W-1], root_im_q[COEF_W-1:HALF_W]}
                               : {1'b0, root_im_q[HALF_W-1:0]};

  // Cell control.
  always_comb begin
    ctl        = '0;
    ctl.mac    = state_q == S_MAC;
    ctl.first  = phase_q == 2'd0;
    ctl.phase  = phase_q;
    ctl.commit = (state_q == S_FIN) && absorb_q;
    ctl.shift  = (state_q == S_EMIT) && (!sym || !emit_cnt_q[0]);
    ctl.clear  = (state_q == S_EMIT) && emit_last;
  end

  // Chain of coefficient cells; cell k sees k-1 below and k+1 above.
  for (genvar k = 0; k < MAX_ROOTS; k++) begin : g_cell
    logic [COEF_W-1:0] left_re, left_im, right_re, right_im;

    if (k == 0) begin : g_bot
      assign left_re = '0;
      assign left_im = '0;
    end else begin : g_mid
      assign left_re = cell_re[k-1];
      assign left_im = cell_im[k-1];
    end

    if (k == MAX_ROOTS - 1) begin : g_top
      assign right_re = '0;
      assign right_im = '0;
    end else begin : g_low
      assign right_re = cell_re[k+1];
      assign right_im = cell_im[k+1];
    end

    rtmp_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (ctl),
      .en_i           (CNT_W'(k) <= seen_q),
      .top_i          (CNT_W'(k) == seen_q),
      .root_re_part_i (rpart_re),
      .root_im_part_i (rpart_im),
      .left_re_i      (left_re),
      .left_im_i      (left_im),
      .right_re_i     (right_re),
      .right_im_i     (right_im),
      .coef_re_o      (cell_re[k]),
      .coef_im_o      (cell_im[k]),
      .sat_o          (cell_sat[k])
    );
  end

  assign any_sat = |cell_sat;

  // Sequencer: accept, square, four multiply phases, commit, send.
  always_comb begin
    state_d    = state_q;
    root_re_d  = root_re_q;
    root_im_d  = root_im_q;
    phase_d    = phase_q;
    absorb_d   = absorb_q;
    seen_d     = seen_q;
    ovf_d      = ovf_q;
    emit_cnt_d = emit_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          root_re_d = {{(COEF_W-ROOT_W){req_i.root_re[ROOT_W-1]}}, req_i.root_re};
          root_im_d = {{(COEF_W-ROOT_W){req_i.root_im[ROOT_W-1]}}, req_i.root_im};
          absorb_d  = active;
          phase_d   = 2'd0;
          if (!active) begin
            state_d = S_FIN;
          end else if (sym) begin
            state_d = S_SQR;
          end else begin
            state_d = S_MAC;
          end
        end
      end
      S_SQR: begin
        root_re_d = sq_re;
        root_im_d = sq_im;
        ovf_d     = ovf_q | sq_sat;
        state_d   = S_MAC;
      end
      S_MAC: begin
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ovf_d  = ovf_q | any_sat;
        seen_d = seen_inc;
        if (seen_inc >= n_roots) begin
          emit_cnt_d = '0;
          state_d    = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_last) begin
          seen_d  = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          emit_cnt_d = emit_cnt_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= 2'd0;
      absorb_q   <= 1'b0;
      seen_q     <= '0;
      ovf_q      <= 1'b0;
      emit_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      absorb_q   <= absorb_d;
      seen_q     <= seen_d;
      ovf_q      <= ovf_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_re_q <= root_re_d;
    root_im_q <= root_im_d;
  end

  assign busy = state_q != S_IDLE;

  // Result: cell zero, or zero at odd powers under sign symmetry.
  always_comb begin
    result_o            = '0;
    result_o.coef_index = IDX_W'(emit_cnt_q);
    result_o.saturated  = ovf_q;
    result_o.last       = emit_last;
    if (!(sym && emit_cnt_q[0])) begin
      result_o.coef_re = cell_re[0];
      result_o.coef_im = cell_im[0];
    end
  end

  assign result_valid_o = state_q == S_EMIT;

  // Checks.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |=> !busy)
    else $error("busy still high after the last result");

  a_odd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && sym && result_o.coef_index[0]
    |-> result_o.coef_re == '0 && result_o.coef_im == '0)
    else $error("odd coefficient not zero under sign symmetry");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= CNT_W'(MAX_ROOTS))
    else $error("root counter beyond the cell count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |=> seen_q == '0 && !ovf_q)
    else $error("state not cleared after the element");

endmodule

// ----- design/rtmp_square.sv -----
// ----------------------------------------------------------------------------
// rtmp_square: complex squaring of one root
//
// Forms r*r exactly from the Q16.16 root, floors it to FRAC_BITS fraction
// bits and saturates both parts to the 48 bit coefficient range.
// ----------------------------------------------------------------------------
module rtmp_square import rtmp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic [ROOT_W-1:0] re_i,
  input  logic [ROOT_W-1:0] im_i,
  output logic [COEF_W-1:0] sq_re_o,
  output logic [COEF_W-1:0] sq_im_o,
  output logic              sat_o
);

  localparam int unsigned PROD_W = 2 * ROOT_W;
  localparam int unsigned SQ_W   = PROD_W + 2;

  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri;
  logic [SQ_W-1:0]          sum_re, sum_im, sh_re, sh_im;
  logic [SQ_W-COEF_W:0]     up_re, up_im;
  logic                     fit_re, fit_im;

  // Three exact products of the root parts.
  assign p_rr = $signed(re_i) * $signed(re_i);
  assign p_ii = $signed(im_i) * $signed(im_i);
  assign p_ri = $signed(re_i) * $signed(im_i);

  // Real part re^2 - im^2, imaginary part 2*re*im, both exact.
  assign sum_re = {{(SQ_W-PROD_W){p_rr[PROD_W-1]}}, p_rr}
                - {{(SQ_W-PROD_W){p_ii[PROD_W-1]}}, p_ii};
  assign sum_im = {{(SQ_W-PROD_W-1){p_ri[PROD_W-1]}}, p_ri, 1'b0};

  // Floor to the coefficient's fraction bits.
  assign sh_re = SQ_W'($signed(sum_re) >>> FRAC_BITS);
  assign sh_im = SQ_W'($signed(sum_im) >>> FRAC_BITS);

  // Saturate to 48 bits when the upper bits are not a sign extension.
  assign up_re  = sh_re[SQ_W-1:COEF_W-1];
  assign up_im  = sh_im[SQ_W-1:COEF_W-1];
  assign fit_re = (&up_re) | ~(|up_re);
  assign fit_im = (&up_im) | ~(|up_im);

  assign sq_re_o = fit_re ? sh_re[COEF_W-1:0]
                 : {sh_re[SQ_W-1], {(COEF_W-1){~sh_re[SQ_W-1]}}};
  assign sq_im_o = fit_im ? sh_im[COEF_W-1:0]
                 : {sh_im[SQ_W-1], {(COEF_W-1){~sh_im[SQ_W-1]}}};
  assign sat_o   = ~fit_re | ~fit_im;

endmodule

// ----- design/rtmp_cell.sv -----
// ----------------------------------------------------------------------------
// rtmp_cell: one coefficient of the polynomial
//
// Holds one complex coefficient. Over four phases it accumulates the product
// of the shared root with its coefficient from 25 bit partial products, then
// commits c[k-1] - r*c[k] using its lower neighbor. While results are sent
// the chain shifts toward cell zero.
// ----------------------------------------------------------------------------
module rtmp_cell import rtmp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtmp_ctl_t         ctl_i,
  input  logic              en_i,
  input  logic              top_i,
  input  logic [PART_W-1:0] root_re_part_i,
  input  logic [PART_W-1:0] root_im_part_i,
  input  logic [COEF_W-1:0] left_re_i,
  input  logic [COEF_W-1:0] left_im_i,
  input  logic [COEF_W-1:0] right_re_i,
  input  logic [COEF_W-1:0] right_im_i,
  output logic [COEF_W-1:0] coef_re_o,
  output logic [COEF_W-1:0] coef_im_o,
  output logic              sat_o
);

  localparam int unsigned PROD_W = 2 * PART_W;
  localparam int unsigned ACC_W  = 2 * COEF_W + 2;
  localparam int unsigned DIF_W  = ACC_W + 1;
  localparam logic [COEF_W-1:0] ONE = {{(COEF_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic [COEF_W-1:0]        c_re_q, c_im_q, c_re_d, c_im_d;
  logic [COEF_W-1:0]        eff_re, eff_im;
  logic [PART_W-1:0]        cpart_re, cpart_im;
  logic signed [PROD_W-1:0] p_rr_cr, p_ri_ci, p_rr_ci, p_ri_cr;
  logic [ACC_W-1:0]         term_re, term_im, shf_re, shf_im;
  logic [ACC_W-1:0]         acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic [ACC_W-1:0]         prod_re, prod_im;
  logic [DIF_W-1:0]         dif_re, dif_im;
  logic [DIF_W-COEF_W:0]    up_re, up_im;
  logic                     fit_re, fit_im;
  logic [COEF_W-1:0]        new_re, new_im;

  // The top used cell stands for the implied leading one.
  assign eff_re = top_i ? ONE : c_re_q;
  assign eff_im = top_i ? '0 : c_im_q;

  // Coefficient half for this phase: high half signed, low half unsigned.
  assign cpart_re = ctl_i.phase[0] ? {eff_re[COEF_W-1], eff_re[COEF_W-1:HALF_W]}
                                   : {1'b0, eff_re[HALF_W-1:0]};
  assign cpart_im = ctl_i.phase[0] ? {eff_im[COEF_W-1], eff_im[COEF_W-1:HALF_W]}
                                   : {1'b0, eff_im[HALF_W-1:0]};

  // Four partial products of the complex multiply.
  assign p_rr_cr = $signed(root_re_part_i) * $signed(cpart_re);
  assign p_ri_ci = $signed(root_im_part_i) * $signed(cpart_im);
  assign p_rr_ci = $signed(root_re_part_i) * $signed(cpart_im);
  assign p_ri_cr = $signed(root_im_part_i) * $signed(cpart_re);

  assign term_re = {{(ACC_W-PROD_W){p_rr_cr[PROD_W-1]}}, p_rr_cr}
                 - {{(ACC_W-PROD_W){p_ri_ci[PROD_W-1]}}, p_ri_ci};
  assign term_im = {{(ACC_W-PROD_W){p_rr_ci[PROD_W-1]}}, p_rr_ci}
                 + {{(ACC_W-PROD_W){p_ri_cr[PROD_W-1]}}, p_ri_cr};

  // Weight of the partial product: sum of the two half positions.
  always_comb begin
    case (ctl_i.phase)
      2'd0: begin
        shf_re = term_re;
        shf_im = term_im;
      end
      2'd3: begin
        shf_re = term_re << (2 * HALF_W);
        shf_im = term_im << (2 * HALF_W);
      end
      default: begin
        shf_re = term_re << HALF_W;
        shf_im = term_im << HALF_W;
      end
    endcase
  end

  assign acc_re_d = ctl_i.first ? shf_re : acc_re_q + shf_re;
  assign acc_im_d = ctl_i.first ? shf_im : acc_im_q + shf_im;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mac) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  // Floor the product and subtract it from the lower neighbor.
  assign prod_re = ACC_W'($signed(acc_re_q) >>> FRAC_BITS);
  assign prod_im = ACC_W'($signed(acc_im_q) >>> FRAC_BITS);
  assign dif_re  = {{(DIF_W-COEF_W){left_re_i[COEF_W-1]}}, left_re_i}
                 - {prod_re[ACC_W-1], prod_re};
  assign dif_im  = {{(DIF_W-COEF_W){left_im_i[COEF_W-1]}}, left_im_i}
                 - {prod_im[ACC_W-1], prod_im};

  // Saturate the new coefficient to 48 bits.
  assign up_re  = dif_re[DIF_W-1:COEF_W-1];
  assign up_im  = dif_im[DIF_W-1:COEF_W-1];
  assign fit_re = (&up_re) | ~(|up_re);
  assign fit_im = (&up_im) | ~(|up_im);
  assign new_re = fit_re ? dif_re[COEF_W-1:0]
                : {dif_re[DIF_W-1], {(COEF_W-1){~dif_re[DIF_W-1]}}};
  assign new_im = fit_im ? dif_im[COEF_W-1:0]
                : {dif_im[DIF_W-1], {(COEF_W-1){~dif_im[DIF_W-1]}}};
  assign sat_o  = ctl_i.commit & en_i & (~fit_re | ~fit_im);

  // Coefficient update: clear, commit or shift toward cell zero.
  always_comb begin
    c_re_d = c_re_q;
    c_im_d = c_im_q;
    if (ctl_i.clear) begin
      c_re_d = '0;
      c_im_d = '0;
    end else if (ctl_i.commit && en_i) begin
      c_re_d = new_re;
      c_im_d = new_im;
    end else if (ctl_i.shift) begin
      c_re_d = right_re_i;
      c_im_d = right_im_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_re_q <= '0;
      c_im_q <= '0;
    end else begin
      c_re_q <= c_re_d;
      c_im_q <= c_im_d;
    end
  end

  assign coef_re_o = c_re_q;
  assign coef_im_o = c_im_q;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for roots_to_monic_polynomial
//
// Feeds complex roots through the command handshake, sets root_count and
// sign_symmetry over the APB port between phases and compares every
// coefficient against an in-bench fixed point model of the root product.
// A directed table covers the extremes and the corner cases. Random phases
// follow, each with its own settings and sender idle rate.
// ----------------------------------------------------------------------------
module tb_top;
  import rtmp_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLDOFF     = 8;
  localparam int unsigned ROOT_TARGET = 150;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned NUM_COEFS   = MAX_ROOTS_DEF;
  localparam wide_t       UNIT        = 128'sd1 <<< FRAC_BITS_DEF;
  localparam wide_t       COEF_MAX    = (128'sd1 <<< (COEF_W - 1)) - 1;
  localparam wide_t       COEF_MIN    = -(128'sd1 <<< (COEF_W - 1));

  // One line of the directed plan: a register write or a root.
  typedef struct packed {
    logic                     is_cfg;
    logic                     reg_sel;
    logic [DATA_W-1:0]        value;
    rtmp_req_t                root;
    logic                     known;
    logic signed [COEF_W-1:0] want_re;
    logic signed [COEF_W-1:0] want_im;
  } plan_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  rtmp_req_t         req_i;
  logic              result_valid_o;
  rtmp_res_t         result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Model of the block: coefficient store, element progress and settings.
  logic signed [COEF_W-1:0] poly_re [NUM_COEFS];
  logic signed [COEF_W-1:0] poly_im [NUM_COEFS];
  int unsigned              roots_taken;
  bit                       ovf_hit;
  bit                       step_sat;
  logic [RC_W-1:0]          cfg_count;
  logic                     cfg_sym;

  rtmp_res_t   new_coefs[$];
  rtmp_res_t   pending_coefs[$];
  plan_row_t   plan[$];
  int unsigned mismatches;
  int unsigned cycles;

  roots_to_monic_polynomial DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run time guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%s", msg);
  endtask

  // Saturate an exact value to the 48 bit coefficient range.
  function automatic logic signed [COEF_W-1:0] clip48(input wide_t x);
    if (x > COEF_MAX) begin
      step_sat = 1'b1;
      return COEF_MAX[COEF_W-1:0];
    end
    if (x < COEF_MIN) begin
      step_sat = 1'b1;
      return COEF_MIN[COEF_W-1:0];
    end
    return x[COEF_W-1:0];
  endfunction

  // Multiply the m held coefficients by (z - r); products are floored.
  function automatic void fold_root(input int unsigned m, input wide_t rr, input wide_t ri);
    logic signed [COEF_W-1:0] nr [NUM_COEFS];
    logic signed [COEF_W-1:0] ni [NUM_COEFS];
    wide_t cr, ci, pr, pi, lr, li;
    for (int unsigned k = 0; k <= m; k++) begin
      cr = (k < m) ? wide_t'(poly_re[k]) : UNIT;
      ci = (k < m) ? wide_t'(poly_im[k]) : '0;
      pr = (rr * cr - ri * ci) >>> FRAC_BITS_DEF;
      pi = (rr * ci + ri * cr) >>> FRAC_BITS_DEF;
      lr = (k > 0) ? wide_t'(poly_re[k-1]) : '0;
      li = (k > 0) ? wide_t'(poly_im[k-1]) : '0;
      nr[k] = clip48(lr - pr);
      ni[k] = clip48(li - pi);
    end
    for (int unsigned k = 0; k <= m; k++) begin
      poly_re[k] = nr[k];
      poly_im[k] = ni[k];
    end
  endfunction

  // Advance the model by one root; coefficients of a finished element go
  // to new_coefs.
  function automatic void predict_root(input rtmp_req_t r);
    int unsigned n, used;
    bit          sym;
    wide_t       rr, ri, sq_re, prod_ri;
    logic signed [COEF_W-1:0] qr, qi;
    rtmp_res_t   c;
    new_coefs.delete();
    step_sat = 1'b0;
    rr = wide_t'($signed(r.root_re));
    ri = wide_t'($signed(r.root_im));
    n = cfg_count;
    if (n == 0) n = 1;
    if (n > MAX_ROOTS_DEF) n = MAX_ROOTS_DEF;
    sym = cfg_sym && (n % 2 == 0);
    used = sym ? n / 2 : n;
    if (roots_taken < used) begin
      if (sym) begin
        sq_re = rr * rr - ri * ri;
        prod_ri = rr * ri;
        qr = clip48(sq_re >>> FRAC_BITS_DEF);
        qi = clip48((prod_ri + prod_ri) >>> FRAC_BITS_DEF);
        rr = wide_t'(qr);
        ri = wide_t'(qi);
      end
      fold_root(roots_taken, rr, ri);
    end
    if (step_sat) ovf_hit = 1'b1;
    if (roots_taken < MAX_ROOTS_DEF) roots_taken++;
    if (roots_taken < n) return;
    for (int unsigned i = 0; i < n; i++) begin
      c = '0;
      c.coef_index = i[IDX_W-1:0];
      if (!sym) begin
        c.coef_re = poly_re[i];
        c.coef_im = poly_im[i];
      end else if (i % 2 == 0) begin
        c.coef_re = poly_re[i/2];
        c.coef_im = poly_im[i/2];
      end
      c.saturated = ovf_hit;
      c.last = (i + 1 == n);
      new_coefs.push_back(c);
    end
    for (int unsigned k = 0; k < NUM_COEFS; k++) begin
      poly_re[k] = '0;
      poly_im[k] = '0;
    end
    roots_taken = 0;
    ovf_hit = 1'b0;
  endfunction

  // Hand one root to the block; idle_pct sets how often the sender waits.
  task automatic push_root(input rtmp_req_t r, input int unsigned idle_pct,
                           input logic known = 1'b0,
                           input logic signed [COEF_W-1:0] want_re = '0,
                           input logic signed [COEF_W-1:0] want_im = '0);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while (busy || $urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_root(r);
    if (known) begin
      pending_coefs.push_back('{coef_index: '0, coef_re: want_re, coef_im: want_im,
                                saturated: 1'b0, last: 1'b1});
    end else begin
      foreach (new_coefs[i]) pending_coefs.push_back(new_coefs[i]);
    end
  endtask

  // Stop sending and let every expected coefficient arrive.
  task automatic settle();
    start <= 1'b0;
    while (pending_coefs.size() != 0 || busy) @(posedge clk_i);
    repeat (HOLDOFF) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Write a register over APB, then read it back.
  task automatic write_reg(input logic sel, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == REG_ROOT_COUNT) cfg_count = value[RC_W-1:0];
    else cfg_sym = value[0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_ROOT_COUNT ? (got[RC_W-1:0] !== value[RC_W-1:0]) : (got[0] !== value[0]))
      flag_error($sformatf("readback reg %0d: wrote %h read %h", sel, value, got));
  endtask

  function automatic plan_row_t row_cfg(input logic sel, input logic [DATA_W-1:0] value);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.reg_sel = sel;
    p.value = value;
    return p;
  endfunction

  function automatic plan_row_t row_root(input logic [ROOT_W-1:0] re, input logic [ROOT_W-1:0] im,
                                         input logic known = 1'b0,
                                         input logic signed [COEF_W-1:0] want_re = '0,
                                         input logic signed [COEF_W-1:0] want_im = '0);
    plan_row_t p;
    p = '0;
    p.root.root_re = re;
    p.root.root_im = im;
    p.known = known;
    p.want_re = want_re;
    p.want_im = want_im;
    return p;
  endfunction

  // Mostly small roots that keep the product in range, some raw words and
  // some boundary values.
  function automatic logic [ROOT_W-1:0] random_part();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return ROOT_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    if (pick < 85) return $urandom;
    case ($urandom_range(4))
      0: return 32'h0000_0000;
      1: return 32'h0001_0000;
      2: return 32'hFFFF_0000;
      3: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Check each coefficient against the oldest expectation.
  always @(posedge clk_i) begin : check_coefs
    rtmp_res_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_coefs.size() == 0) begin
        flag_error($sformatf("unexpected coefficient %p", result_o));
      end else begin
        want = pending_coefs.pop_front();
        if (result_o.coef_index !== want.coef_index || result_o.coef_re !== want.coef_re ||
            result_o.coef_im !== want.coef_im || result_o.saturated !== want.saturated ||
            result_o.last !== want.last)
          flag_error($sformatf({"coef mismatch: expected idx %0d re %0d im %0d sat %0b",
                                " last %0b, got idx %0d re %0d im %0d sat %0b last %0b"},
                               want.coef_index, want.coef_re, want.coef_im, want.saturated,
                               want.last, result_o.coef_index, result_o.coef_re,
                               result_o.coef_im, result_o.saturated, result_o.last));
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    int unsigned idle_plan [3];
    int unsigned phase_count [4];
    logic        phase_sym [4];
    int unsigned sent, phase, pct, n, total, broken_at;
    logic [RC_W-1:0] count;
    logic        sym;
    rtmp_req_t   r;
    idle_plan   = '{0, 75, 33};
    phase_count = '{8, 15, 0, 1};
    phase_sym   = '{1'b1, 1'b0, 1'b1, 1'b0};
    cycles      = 0;
    mismatches  = 0;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    req_i   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    for (int unsigned k = 0; k < NUM_COEFS; k++) begin
      poly_re[k] = '0;
      poly_im[k] = '0;
    end
    roots_taken = 0;
    ovf_hit = 1'b0;
    cfg_count = RC_W'(1);
    cfg_sym = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one root per element, so the coefficient is -r.
    plan.push_back(row_root(32'h0000_0000, 32'h0000_0000, 1'b1, 48'sd0, 48'sd0));
    plan.push_back(row_root(32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                            -48'sd2147483647, 48'sd2147483648));
    plan.push_back(row_root(32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                            48'sd2147483648, -48'sd2147483647));
    plan.push_back(row_root(32'h0001_0000, 32'hFFFF_FFFF, 1'b1, -48'sd65536, 48'sd1));
    // A root count of zero acts as one.
    plan.push_back(row_cfg(REG_ROOT_COUNT, 32'd0));
    plan.push_back(row_root(32'h0002_8000, 32'hFFFE_0000));
    // Symmetric pair: the squaring overflows, the second root is ignored.
    plan.push_back(row_cfg(REG_ROOT_COUNT, 32'd2));
    plan.push_back(row_cfg(REG_SIGN_SYM, 32'd1));
    plan.push_back(row_root(32'h8000_0000, 32'h8000_0000));
    plan.push_back(row_root(32'h1234_5678, 32'h9ABC_DEF0));
    // Odd count with symmetry set: all roots used as they are.
    plan.push_back(row_cfg(REG_ROOT_COUNT, 32'd3));
    plan.push_back(row_root(32'h0001_0000, 32'h0000_0000));
    plan.push_back(row_root(32'hFFFF_0000, 32'h0000_8000));
    plan.push_back(row_root(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // Count above the maximum saturates to eight; half the roots are squared.
    plan.push_back(row_cfg(REG_ROOT_COUNT, 32'd15));
    plan.push_back(row_root(32'h7FFF_FFFF, 32'h0000_0000));
    plan.push_back(row_root(32'h0000_0000, 32'h7FFF_FFFF));
    plan.push_back(row_root(32'h0003_0000, 32'h0001_0000));
    plan.push_back(row_root(32'hFFFD_0000, 32'h0002_0000));
    plan.push_back(row_root(32'h5555_5555, 32'hAAAA_AAAA));
    plan.push_back(row_root(32'hAAAA_AAAA, 32'h5555_5555));
    plan.push_back(row_root(32'h0000_0000, 32'h0000_0000));
    plan.push_back(row_root(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Count lowered in the middle of an element: the next root ends it.
    plan.push_back(row_cfg(REG_SIGN_SYM, 32'd0));
    plan.push_back(row_cfg(REG_ROOT_COUNT, 32'd4));
    plan.push_back(row_root(32'h0001_8000, 32'hFFFF_4000));
    plan.push_back(row_root(32'hFFFE_0000, 32'h0000_C000));
    plan.push_back(row_cfg(REG_ROOT_COUNT, 32'd2));
    plan.push_back(row_root(32'h0004_0000, 32'h0004_0000));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].value);
      end else begin
        push_root(plan[i].root, 0, plan[i].known, plan[i].want_re, plan[i].want_im);
      end
    end

    // Random phases: new settings, whole elements, now and then a count
    // change in the middle of an element.
    sent = 0;
    phase = 0;
    while (sent < ROOT_TARGET) begin
      pct = idle_plan[phase % 3];
      if (phase < 4) begin
        count = RC_W'(phase_count[phase]);
        sym = phase_sym[phase];
      end else begin
        count = RC_W'($urandom_range(0, 15));
        sym = 1'($urandom_range(1));
      end
      settle();
      write_reg(REG_ROOT_COUNT, {$urandom} & ~32'hF | 32'(count));
      write_reg(REG_SIGN_SYM, {$urandom} & ~32'h1 | 32'(sym));
      n = (count == 0) ? 1 : (count > MAX_ROOTS_DEF) ? MAX_ROOTS_DEF : count;
      total = ((16 + n - 1) / n) * n;
      broken_at = ($urandom_range(7) == 0) ? $urandom_range(1, total - 1) : total;
      for (int unsigned j = 0; j < total; j++) begin
        if (j == broken_at && j != 0) begin
          settle();
          write_reg(REG_ROOT_COUNT, 32'($urandom_range(0, 15)));
        end
        r.root_re = random_part();
        r.root_im = random_part();
        push_root(r, pct);
      end
      sent += total;
      phase++;
    end

    settle();
    repeat (HOLDOFF) @(posedge clk_i);
    if (pending_coefs.size() != 0)
      flag_error($sformatf("%0d coefficients never arrived", pending_coefs.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
